/* src/isot0_pkg.sv */
`default_nettype none
package isot0_pkg;

  typedef enum logic [1:0] {
    ACT_TICK  = 2'd0,
    ACT_TX    = 2'd1,
    ACT_RX    = 2'd2,
    ACT_SPARE = 2'd3
  } action_e;

  typedef enum logic [2:0] {
    REG_BIT_PERIOD     = 3'd0,
    REG_SAMPLE_FIRST   = 3'd1,
    REG_SAMPLE_SECOND  = 3'd2,
    REG_SAMPLE_THIRD   = 3'd3,
    REG_ERROR_CHECK    = 3'd4,
    REG_STOP_GUARD     = 3'd5,
    REG_ERROR_SIG_END  = 3'd6,
    REG_UNUSED         = 3'd7
  } reg_idx_e;

  localparam logic [7:0] TxPreload      = 8'd40;
  localparam logic [7:0] TxRetryPreload = 8'd22;

  localparam logic [7:0] RstBitPeriod   = 8'd46;
  localparam logic [7:0] RstSampleFirst = 8'd12;
  localparam logic [7:0] RstSampleSec   = 8'd23;
  localparam logic [7:0] RstSampleThird = 8'd34;
  localparam logic [7:0] RstErrorCheck  = 8'd93;
  localparam logic [7:0] RstStopGuard   = 8'd139;
  localparam logic [7:0] RstErrSigEnd   = 8'd162;

  typedef struct packed {
    logic [7:0] bit_period;
    logic [7:0] sample_first;
    logic [7:0] sample_second;
    logic [7:0] sample_third;
    logic [7:0] error_check_time;
    logic [7:0] stop_guard_time;
    logic [7:0] error_signal_end;
  } cfg_t;

  typedef struct packed {
    logic       drive_enable;
    logic       drive_level;
    logic       pullup_enable;
    logic [7:0] rx_data;
    logic       rx_valid;
    logic       tx_done;
    logic       retry_event;
    logic       busy_res;
  } res_t;

endpackage
`default_nettype wire

/* src/isot0_core.sv */
`default_nettype none
module isot0_core #(
  parameter int COUNTER_BITS = 8
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                step_i,
  input  wire logic [1:0]          action_i,
  input  wire logic [7:0]          tx_byte_i,
  input  wire logic                line_level_i,
  input  wire isot0_pkg::cfg_t     cfg_i,
  output      isot0_pkg::res_t     res_o
);
  import isot0_pkg::*;

  typedef enum logic [3:0] {
    PH_IDLE        = 4'd0,
    PH_TX_BIT      = 4'd1,
    PH_TX_RELEASE  = 4'd2,
    PH_TX_CHECK    = 4'd3,
    PH_TX_ERRWAIT  = 4'd4,
    PH_RX_START    = 4'd5,
    PH_RX_BITWAIT  = 4'd6,
    PH_RX_S1       = 4'd7,
    PH_RX_S2       = 4'd8,
    PH_RX_S3       = 4'd9,
    PH_RX_CHECK    = 4'd10,
    PH_RX_ERRDRIVE = 4'd11,
    PH_RX_GUARD    = 4'd12
  } phase_e;

  localparam int unsigned CW = COUNTER_BITS;

  phase_e          phase_q, phase_d;
  logic [CW-1:0]   tick_q, tick_d;
  logic [7:0]      shift_q, shift_d;
  logic [7:0]      saved_q, saved_d;
  logic [3:0]      bit_idx_q, bit_idx_d;
  logic            parity_q, parity_d;
  logic [1:0]      vote_q, vote_d;
  logic            start_low_q, start_low_d;
  logic            line_out_q, line_out_d;
  logic [7:0]      rx_hold_q, rx_hold_d;

  logic            reload;
  logic            rxv, txd, retry;
  logic            tx_bit;
  logic [1:0]      vote_sum;
  logic            vote_bit;
  logic            de;

  // all timing compares against the free counter, registers zero-extended
  logic ge_period, ge_s1, ge_s2, ge_s3, ge_check, ge_guard, ge_errend;
  assign ge_period = tick_q >= CW'(cfg_i.bit_period);
  assign ge_s1     = tick_q >= CW'(cfg_i.sample_first);
  assign ge_s2     = tick_q >= CW'(cfg_i.sample_second);
  assign ge_s3     = tick_q >= CW'(cfg_i.sample_third);
  assign ge_check  = tick_q >= CW'(cfg_i.error_check_time);
  assign ge_guard  = tick_q >= CW'(cfg_i.stop_guard_time);
  assign ge_errend = tick_q >= CW'(cfg_i.error_signal_end);

  assign vote_sum = vote_q + {1'b0, line_level_i};
  assign vote_bit = vote_sum[1];

  always_comb begin
    case (bit_idx_q)
      4'd0:    tx_bit = 1'b0;
      4'd1:    tx_bit = saved_q[0];
      4'd2:    tx_bit = saved_q[1];
      4'd3:    tx_bit = saved_q[2];
      4'd4:    tx_bit = saved_q[3];
      4'd5:    tx_bit = saved_q[4];
      4'd6:    tx_bit = saved_q[5];
      4'd7:    tx_bit = saved_q[6];
      4'd8:    tx_bit = saved_q[7];
      4'd9:    tx_bit = parity_q;
      default: tx_bit = 1'b1;
    endcase
  end

  always_comb begin
    phase_d     = phase_q;
    tick_d      = tick_q;
    shift_d     = shift_q;
    saved_d     = saved_q;
    bit_idx_d   = bit_idx_q;
    parity_d    = parity_q;
    vote_d      = vote_q;
    start_low_d = start_low_q;
    line_out_d  = line_out_q;
    rx_hold_d   = rx_hold_q;
    reload      = 1'b0;
    rxv         = 1'b0;
    txd         = 1'b0;
    retry       = 1'b0;

    case (phase_q)
      PH_IDLE: begin
        if (action_i == ACT_TX) begin
          saved_d    = tx_byte_i;
          phase_d    = PH_TX_BIT;
          tick_d     = CW'(TxPreload);
          bit_idx_d  = '0;
          parity_d   = 1'b0;
          line_out_d = 1'b1;
        end else if (action_i == ACT_RX) begin
          phase_d     = PH_RX_START;
          start_low_d = 1'b0;
          line_out_d  = 1'b1;
        end
        reload = 1'b1;
      end
      PH_TX_BIT: begin
        if (ge_period) begin
          line_out_d = tx_bit;
          if (bit_idx_q >= 4'd1 && bit_idx_q <= 4'd8) parity_d = parity_q ^ tx_bit;
          tick_d    = '0;
          reload    = 1'b1;
          bit_idx_d = bit_idx_q + 4'd1;
          if (bit_idx_d >= 4'd11) phase_d = PH_TX_RELEASE;
        end
      end
      PH_TX_RELEASE: begin
        if (ge_period) phase_d = PH_TX_CHECK;
      end
      PH_TX_CHECK: begin
        if (ge_check) begin
          if (!line_level_i) begin
            retry   = 1'b1;
            phase_d = PH_TX_ERRWAIT;
          end else begin
            txd     = 1'b1;
            phase_d = PH_IDLE;
            reload  = 1'b1;
          end
        end
      end
      PH_TX_ERRWAIT: begin
        // card released the line: resend with a longer lead-in
        if (line_level_i) begin
          phase_d    = PH_TX_BIT;
          tick_d     = CW'(TxRetryPreload);
          bit_idx_d  = '0;
          parity_d   = 1'b0;
          line_out_d = 1'b1;
          reload     = 1'b1;
        end
      end
      PH_RX_START: begin
        if (!line_level_i) begin
          if (start_low_q) begin
            tick_d    = '0;
            reload    = 1'b1;
            bit_idx_d = '0;
            shift_d   = '0;
            parity_d  = 1'b0;
            phase_d   = PH_RX_BITWAIT;
          end
          start_low_d = 1'b1;
        end else begin
          start_low_d = 1'b0;
        end
      end
      PH_RX_BITWAIT: begin
        if (ge_period) begin
          tick_d  = '0;
          reload  = 1'b1;
          vote_d  = '0;
          phase_d = PH_RX_S1;
        end
      end
      PH_RX_S1: begin
        if (ge_s1) begin
          vote_d  = {1'b0, line_level_i};
          phase_d = PH_RX_S2;
        end
      end
      PH_RX_S2: begin
        if (ge_s2) begin
          vote_d  = vote_sum;
          phase_d = PH_RX_S3;
        end
      end
      PH_RX_S3: begin
        if (ge_s3) begin
          vote_d   = vote_sum;
          parity_d = parity_q ^ vote_bit;
          if (bit_idx_q < 4'd8) begin
            shift_d   = {vote_bit, shift_q[7:1]};
            bit_idx_d = bit_idx_q + 4'd1;
            phase_d   = PH_RX_BITWAIT;
          end else begin
            phase_d = PH_RX_CHECK;
          end
        end
      end
      PH_RX_CHECK: begin
        if (ge_check) begin
          if (parity_q) begin
            retry      = 1'b1;
            line_out_d = 1'b0;
            phase_d    = PH_RX_ERRDRIVE;
          end else begin
            phase_d = PH_RX_GUARD;
          end
        end
      end
      PH_RX_ERRDRIVE: begin
        if (ge_errend) begin
          phase_d     = PH_RX_START;
          start_low_d = 1'b0;
          line_out_d  = 1'b1;
        end
      end
      PH_RX_GUARD: begin
        if (ge_guard) begin
          rx_hold_d = shift_q;
          rxv       = 1'b1;
          phase_d   = PH_IDLE;
          reload    = 1'b1;
        end
      end
      default: begin
        phase_d = PH_IDLE;
        reload  = 1'b1;
      end
    endcase

    // saturating count unless this beat reloaded the counter
    if (!reload && tick_q != '1) tick_d = tick_q + CW'(1);
  end

  assign de = (phase_d == PH_TX_BIT) || (phase_d == PH_TX_RELEASE) ||
              (phase_d == PH_RX_ERRDRIVE);

  always_comb begin
    res_o.drive_enable  = de;
    res_o.drive_level   = de & line_out_d;
    res_o.pullup_enable = (phase_d >= PH_RX_START) && (phase_d <= PH_RX_GUARD) &&
                          (phase_d != PH_RX_ERRDRIVE);
    res_o.rx_data       = rx_hold_d;
    res_o.rx_valid      = rxv;
    res_o.tx_done       = txd;
    res_o.retry_event   = retry;
    res_o.busy_res      = phase_d != PH_IDLE;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_IDLE;
      tick_q      <= '0;
      shift_q     <= '0;
      saved_q     <= '0;
      bit_idx_q   <= '0;
      parity_q    <= 1'b0;
      vote_q      <= '0;
      start_low_q <= 1'b0;
      line_out_q  <= 1'b1;
      rx_hold_q   <= '0;
    end else if (step_i) begin
      phase_q     <= phase_d;
      tick_q      <= tick_d;
      shift_q     <= shift_d;
      saved_q     <= saved_d;
      bit_idx_q   <= bit_idx_d;
      parity_q    <= parity_d;
      vote_q      <= vote_d;
      start_low_q <= start_low_d;
      line_out_q  <= line_out_d;
      rx_hold_q   <= rx_hold_d;
    end
  end

endmodule
`default_nettype wire

/* src/iso7816_t0_char_transceiver.sv */
`default_nettype none
// channel | handshake                    | payload
// --------+------------------------------+------------------------------------------
// tick in | in_valid_i / in_stall_o      | action_i, tx_byte_i, line_level_i
// result  | out_valid_o / out_stall_i    | drive_enable_o .. busy_res_o
// config  | cfg_we_i                     | cfg_index_i, cfg_wdata_i
//
// one tick beat in, one result beat out; a beat is taken every cycle while in_stall_o is low
// the result appears in the cycle after its tick beat is taken, from the result register
// in_stall_o is high only while a result is held and the output is stalled
// reset returns the sequencer to idle and the timing registers to their defaults
module iso7816_t0_char_transceiver #(
  parameter int COUNTER_BITS = 8
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output      logic       in_stall_o,
  input  wire logic [1:0] action_i,
  input  wire logic [7:0] tx_byte_i,
  input  wire logic       line_level_i,
  output      logic       out_valid_o,
  input  wire logic       out_stall_i,
  output      logic       drive_enable_o,
  output      logic       drive_level_o,
  output      logic       pullup_enable_o,
  output      logic [7:0] rx_data_o,
  output      logic       rx_valid_o,
  output      logic       tx_done_o,
  output      logic       retry_event_o,
  output      logic       busy_res_o,
  input  wire logic       cfg_we_i,
  input  wire logic [2:0] cfg_index_i,
  input  wire logic [7:0] cfg_wdata_i
);
  import isot0_pkg::*;

  cfg_t cfg_q;
  res_t res_d, res_q;
  logic out_valid_q;
  logic accept;

  assign in_stall_o = out_valid_q & out_stall_i;
  assign accept     = in_valid_i & ~in_stall_o;

  isot0_core #(
    .COUNTER_BITS(COUNTER_BITS)
  ) u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .step_i       (accept),
    .action_i     (action_i),
    .tx_byte_i    (tx_byte_i),
    .line_level_i (line_level_i),
    .cfg_i        (cfg_q),
    .res_o        (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.bit_period       <= RstBitPeriod;
      cfg_q.sample_first     <= RstSampleFirst;
      cfg_q.sample_second    <= RstSampleSec;
      cfg_q.sample_third     <= RstSampleThird;
      cfg_q.error_check_time <= RstErrorCheck;
      cfg_q.stop_guard_time  <= RstStopGuard;
      cfg_q.error_signal_end <= RstErrSigEnd;
    end else if (cfg_we_i) begin
      case (reg_idx_e'(cfg_index_i))
        REG_BIT_PERIOD:    cfg_q.bit_period       <= cfg_wdata_i;
        REG_SAMPLE_FIRST:  cfg_q.sample_first     <= cfg_wdata_i;
        REG_SAMPLE_SECOND: cfg_q.sample_second    <= cfg_wdata_i;
        REG_SAMPLE_THIRD:  cfg_q.sample_third     <= cfg_wdata_i;
        REG_ERROR_CHECK:   cfg_q.error_check_time <= cfg_wdata_i;
        REG_STOP_GUARD:    cfg_q.stop_guard_time  <= cfg_wdata_i;
        REG_ERROR_SIG_END: cfg_q.error_signal_end <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) res_q <= res_d;
  end

  assign out_valid_o     = out_valid_q;
  assign drive_enable_o  = res_q.drive_enable;
  assign drive_level_o   = res_q.drive_level;
  assign pullup_enable_o = res_q.pullup_enable;
  assign rx_data_o       = res_q.rx_data;
  assign rx_valid_o      = res_q.rx_valid;
  assign tx_done_o       = res_q.tx_done;
  assign retry_event_o   = res_q.retry_event;
  assign busy_res_o      = res_q.busy_res;

endmodule
`default_nettype wire

/* verif/iso7816_t0_char_transceiver_test.sv */
module iso7816_t0_char_transceiver_test;
  timeunit 1ns;
  timeprecision 1ps;

  import isot0_pkg::*;

  localparam int CycleLimit = 20000;
  // stretch of cycles with no idling on either side
  localparam int CalmFrom = 200;
  localparam int CalmTo = 400;

  typedef enum logic [3:0] {
    PH_IDLE, PH_TX_BIT, PH_TX_RELEASE, PH_TX_CHECK, PH_TX_ERRWAIT,
    PH_RX_START, PH_RX_BITWAIT, PH_RX_S1, PH_RX_S2, PH_RX_S3,
    PH_RX_CHECK, PH_RX_ERRDRIVE, PH_RX_GUARD
  } t0_phase_e;

  typedef struct {
    t0_phase_e  ph;
    logic [7:0] cnt;
    logic [7:0] shreg;
    logic [7:0] saved;
    logic [3:0] bidx;
    logic       par;
    logic [1:0] votes;
    logic       low_seen;
    logic       lout;
    logic [7:0] rx_hold;
  } t0_state_t;

  typedef struct packed {
    action_e    act;
    logic [7:0] tx_data;
    logic       line;
  } tick_beat_t;

  logic       clk_i;
  logic       rst_ni;
  logic       in_valid_i;
  logic       in_stall_o;
  logic [1:0] action_i;
  logic [7:0] tx_byte_i;
  logic       line_level_i;
  logic       out_valid_o;
  logic       out_stall_i;
  logic       drive_enable_o;
  logic       drive_level_o;
  logic       pullup_enable_o;
  logic [7:0] rx_data_o;
  logic       rx_valid_o;
  logic       tx_done_o;
  logic       retry_event_o;
  logic       busy_res_o;
  logic       cfg_we_i;
  logic [2:0] cfg_index_i;
  logic [7:0] cfg_wdata_i;

  iso7816_t0_char_transceiver DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .action_i        (action_i),
    .tx_byte_i       (tx_byte_i),
    .line_level_i    (line_level_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .drive_enable_o  (drive_enable_o),
    .drive_level_o   (drive_level_o),
    .pullup_enable_o (pullup_enable_o),
    .rx_data_o       (rx_data_o),
    .rx_valid_o      (rx_valid_o),
    .tx_done_o       (tx_done_o),
    .retry_event_o   (retry_event_o),
    .busy_res_o      (busy_res_o),
    .cfg_we_i        (cfg_we_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_wdata_i     (cfg_wdata_i)
  );

  cfg_t       timing;
  t0_state_t  stim_state;
  t0_state_t  pred_state;
  tick_beat_t tick_backlog[$];
  res_t       line_outputs_due[$];
  bit         in_taken;
  int         cycle;
  int         mismatches;
  int         gen_count;
  int         n_beats;
  int         n_settings;
  int         n_sent;
  int         n_received;
  int         n_retries;

  always #2 clk_i = ~clk_i;

  function automatic t0_state_t t0_idle_state();
    t0_state_t s;
    s.ph = PH_IDLE;
    s.cnt = '0;
    s.shreg = '0;
    s.saved = '0;
    s.bidx = '0;
    s.par = 1'b0;
    s.votes = '0;
    s.low_seen = 1'b0;
    s.lout = 1'b1;
    s.rx_hold = '0;
    return s;
  endfunction

  function automatic t0_state_t launch_tx(t0_state_t s, logic [7:0] preload);
    s.ph = PH_TX_BIT;
    s.cnt = preload;
    s.bidx = '0;
    s.par = 1'b0;
    s.lout = 1'b1;
    return s;
  endfunction

  function automatic t0_state_t listen_rx(t0_state_t s);
    s.ph = PH_RX_START;
    s.low_seen = 1'b0;
    s.lout = 1'b1;
    return s;
  endfunction

  // one prescaled tick through the character sequencer
  task automatic predict_char_tick(input t0_state_t cur, input cfg_t c, input action_e act,
                                   input logic [7:0] txb, input logic line,
                                   output t0_state_t s, output res_t r);
    logic       reload;
    logic       bit_v;
    logic [1:0] sum;
    s = cur;
    reload = 1'b0;
    r = '0;
    case (s.ph)
      PH_IDLE: begin
        if (act == ACT_TX) begin
          s.saved = txb;
          s = launch_tx(s, TxPreload);
        end else if (act == ACT_RX) begin
          s = listen_rx(s);
        end
        reload = 1'b1;
      end
      PH_TX_BIT: begin
        if (s.cnt >= c.bit_period) begin
          if (s.bidx == 4'd0) begin
            bit_v = 1'b0;
          end else if (s.bidx <= 4'd8) begin
            bit_v = s.saved[s.bidx - 4'd1];
            s.par = s.par ^ bit_v;
          end else if (s.bidx == 4'd9) begin
            bit_v = s.par;
          end else begin
            bit_v = 1'b1;
          end
          s.lout = bit_v;
          s.cnt = '0;
          reload = 1'b1;
          s.bidx = s.bidx + 4'd1;
          if (s.bidx >= 4'd11) s.ph = PH_TX_RELEASE;
        end
      end
      PH_TX_RELEASE: begin
        if (s.cnt >= c.bit_period) s.ph = PH_TX_CHECK;
      end
      PH_TX_CHECK: begin
        if (s.cnt >= c.error_check_time) begin
          if (!line) begin
            r.retry_event = 1'b1;
            s.ph = PH_TX_ERRWAIT;
          end else begin
            r.tx_done = 1'b1;
            s.ph = PH_IDLE;
            reload = 1'b1;
          end
        end
      end
      PH_TX_ERRWAIT: begin
        if (line) begin
          s = launch_tx(s, TxRetryPreload);
          reload = 1'b1;
        end
      end
      PH_RX_START: begin
        if (!line) begin
          if (s.low_seen) begin
            s.cnt = '0;
            reload = 1'b1;
            s.bidx = '0;
            s.shreg = '0;
            s.par = 1'b0;
            s.ph = PH_RX_BITWAIT;
          end
          s.low_seen = 1'b1;
        end else begin
          s.low_seen = 1'b0;
        end
      end
      PH_RX_BITWAIT: begin
        if (s.cnt >= c.bit_period) begin
          s.cnt = '0;
          reload = 1'b1;
          s.votes = '0;
          s.ph = PH_RX_S1;
        end
      end
      PH_RX_S1: begin
        if (s.cnt >= c.sample_first) begin
          s.votes = {1'b0, line};
          s.ph = PH_RX_S2;
        end
      end
      PH_RX_S2: begin
        if (s.cnt >= c.sample_second) begin
          s.votes = s.votes + {1'b0, line};
          s.ph = PH_RX_S3;
        end
      end
      PH_RX_S3: begin
        if (s.cnt >= c.sample_third) begin
          sum = s.votes + {1'b0, line};
          bit_v = (sum >= 2'd2);
          s.votes = sum;
          s.par = s.par ^ bit_v;
          if (s.bidx < 4'd8) begin
            s.shreg = {bit_v, s.shreg[7:1]};
            s.bidx = s.bidx + 4'd1;
            s.ph = PH_RX_BITWAIT;
          end else begin
            s.ph = PH_RX_CHECK;
          end
        end
      end
      PH_RX_CHECK: begin
        if (s.cnt >= c.error_check_time) begin
          if (s.par) begin
            r.retry_event = 1'b1;
            s.lout = 1'b0;
            s.ph = PH_RX_ERRDRIVE;
          end else begin
            s.ph = PH_RX_GUARD;
          end
        end
      end
      PH_RX_ERRDRIVE: begin
        if (s.cnt >= c.error_signal_end) s = listen_rx(s);
      end
      PH_RX_GUARD: begin
        if (s.cnt >= c.stop_guard_time) begin
          s.rx_hold = s.shreg;
          r.rx_valid = 1'b1;
          s.ph = PH_IDLE;
          reload = 1'b1;
        end
      end
      default: begin
        s.ph = PH_IDLE;
        reload = 1'b1;
      end
    endcase
    // counter saturates at its top value
    if (!reload && s.cnt != 8'hFF) s.cnt = s.cnt + 8'd1;
    r.drive_enable = (s.ph == PH_TX_BIT || s.ph == PH_TX_RELEASE || s.ph == PH_RX_ERRDRIVE);
    r.drive_level = r.drive_enable & s.lout;
    r.pullup_enable = (s.ph >= PH_RX_START && s.ph <= PH_RX_GUARD && s.ph != PH_RX_ERRDRIVE);
    r.rx_data = s.rx_hold;
    r.busy_res = (s.ph != PH_IDLE);
  endtask

  function automatic bit take_break();
    return !(cycle >= CalmFrom && cycle < CalmTo) && ($urandom_range(99) < 11);
  endfunction

  task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
      mismatches++;
    end
  endtask

  // the stimulus side keeps its own copy of the sequencer so the card can answer in step
  task automatic push_tick(input action_e act, input logic [7:0] data, input logic line);
    t0_state_t  nxt;
    res_t       ignored;
    tick_beat_t beat;
    predict_char_tick(stim_state, timing, act, data, line, nxt, ignored);
    stim_state = nxt;
    beat.act = act;
    beat.tx_data = data;
    beat.line = line;
    tick_backlog.push_back(beat);
    gen_count++;
  endtask

  task automatic gen_transfer(input action_e kind, input logic [7:0] data, input bit bad_first,
                              input int hold);
    t0_phase_e  prev;
    logic [7:0] d;
    logic [8:0] frame_bits;
    bit         line_err;
    int         low_left;
    int         guard;
    action_e    act;
    logic       line;
    line_err = bad_first;
    low_left = hold;
    guard = 0;
    frame_bits = {(^data) ^ bad_first, data};
    repeat ($urandom_range(0, 3))
      push_tick(($urandom_range(9) == 0) ? ACT_SPARE : ACT_TICK, 8'($urandom), 1'($urandom));
    push_tick(kind, data, 1'($urandom));
    while (stim_state.ph != PH_IDLE && guard < 6000) begin
      case (stim_state.ph)
        PH_TX_CHECK: begin
          line = !line_err;
          if ($urandom_range(99) < 5) line = !line;
        end
        PH_TX_ERRWAIT: begin
          if (low_left > 0) begin
            line = 1'b0;
            low_left--;
          end else begin
            line = ($urandom_range(99) < 40);
          end
        end
        PH_RX_START: line = ($urandom_range(99) >= 60);
        PH_RX_BITWAIT: line = frame_bits[stim_state.bidx];
        PH_RX_S1, PH_RX_S2, PH_RX_S3: begin
          line = frame_bits[stim_state.bidx];
          if ($urandom_range(99) < 10) line = !line;
        end
        PH_RX_CHECK, PH_RX_GUARD: line = ($urandom_range(99) < 90);
        default: line = 1'($urandom);
      endcase
      // starts while busy must be ignored
      if ($urandom_range(99) < 3) act = action_e'($urandom_range(3, 1));
      else act = ACT_TICK;
      prev = stim_state.ph;
      push_tick(act, 8'($urandom), line);
      if (prev == PH_TX_ERRWAIT && stim_state.ph == PH_TX_BIT) begin
        line_err = ($urandom_range(99) < 25);
        low_left = $urandom_range(0, 3);
      end
      if (prev == PH_RX_ERRDRIVE && stim_state.ph == PH_RX_START) begin
        d = 8'($urandom);
        frame_bits = {(^d) ^ ($urandom_range(99) < 25), d};
      end
      guard++;
    end
  endtask

  task automatic write_reg(input reg_idx_e idx, input logic [7:0] v);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= v;
    case (idx)
      REG_BIT_PERIOD:    timing.bit_period = v;
      REG_SAMPLE_FIRST:  timing.sample_first = v;
      REG_SAMPLE_SECOND: timing.sample_second = v;
      REG_SAMPLE_THIRD:  timing.sample_third = v;
      REG_ERROR_CHECK:   timing.error_check_time = v;
      REG_STOP_GUARD:    timing.stop_guard_time = v;
      REG_ERROR_SIG_END: timing.error_signal_end = v;
      default: ;
    endcase
  endtask

  task automatic apply_timing(input cfg_t c, input bit poke_spare);
    write_reg(REG_BIT_PERIOD, c.bit_period);
    write_reg(REG_SAMPLE_FIRST, c.sample_first);
    write_reg(REG_SAMPLE_SECOND, c.sample_second);
    write_reg(REG_SAMPLE_THIRD, c.sample_third);
    write_reg(REG_ERROR_CHECK, c.error_check_time);
    write_reg(REG_STOP_GUARD, c.stop_guard_time);
    write_reg(REG_ERROR_SIG_END, c.error_signal_end);
    if (poke_spare) write_reg(REG_UNUSED, 8'($urandom));
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    n_settings++;
    @(posedge clk_i);
  endtask

  task automatic wait_settled();
    do @(negedge clk_i); while (n_beats < gen_count);
    repeat (2) @(negedge clk_i);
  endtask

  always @(posedge clk_i) begin
    cycle++;
    if (cycle > CycleLimit) begin
      $display("%0t: timed out with %0d result beats outstanding", $time, gen_count - n_beats);
      $display("Some tests failed");
      $finish;
    end
  end

  always @(negedge clk_i) begin
    tick_beat_t nb;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (!in_valid_i || in_taken) begin
      if (tick_backlog.size() != 0 && !take_break()) begin
        nb = tick_backlog.pop_front();
        in_valid_i <= 1'b1;
        action_i <= nb.act;
        tx_byte_i <= nb.tx_data;
        line_level_i <= nb.line;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  always @(negedge clk_i) begin
    out_stall_i <= rst_ni ? take_break() : 1'b0;
  end

  always @(posedge clk_i) begin
    res_t      got;
    res_t      want;
    res_t      pred;
    t0_state_t nxt;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        got.drive_enable = drive_enable_o;
        got.drive_level = drive_level_o;
        got.pullup_enable = pullup_enable_o;
        got.rx_data = rx_data_o;
        got.rx_valid = rx_valid_o;
        got.tx_done = tx_done_o;
        got.retry_event = retry_event_o;
        got.busy_res = busy_res_o;
        if (line_outputs_due.size() == 0) begin
          $display("%0t: result beat %0h with nothing expected", $time, got);
          mismatches++;
        end else begin
          want = line_outputs_due.pop_front();
          check_field("drive_enable", 8'(want.drive_enable), 8'(got.drive_enable));
          check_field("drive_level", 8'(want.drive_level), 8'(got.drive_level));
          check_field("pullup_enable", 8'(want.pullup_enable), 8'(got.pullup_enable));
          check_field("rx_data", want.rx_data, got.rx_data);
          check_field("rx_valid", 8'(want.rx_valid), 8'(got.rx_valid));
          check_field("tx_done", 8'(want.tx_done), 8'(got.tx_done));
          check_field("retry_event", 8'(want.retry_event), 8'(got.retry_event));
          check_field("busy_res", 8'(want.busy_res), 8'(got.busy_res));
        end
        n_beats++;
        n_sent += got.tx_done;
        n_received += got.rx_valid;
        n_retries += got.retry_event;
      end
      in_taken = in_valid_i && !in_stall_o;
      if (in_taken) begin
        predict_char_tick(pred_state, timing, action_e'(action_i), tx_byte_i, line_level_i,
                          nxt, pred);
        pred_state = nxt;
        line_outputs_due.push_back(pred);
      end
    end else begin
      in_taken = 1'b0;
    end
  end

  initial begin
    cfg_t c;
    int   base;
    int   pick;
    action_e kind;
    clk_i = 1'b0;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    action_i = ACT_TICK;
    tx_byte_i = '0;
    line_level_i = 1'b1;
    out_stall_i = 1'b0;
    cfg_we_i = 1'b0;
    cfg_index_i = REG_BIT_PERIOD;
    cfg_wdata_i = '0;
    in_taken = 1'b0;
    cycle = 0;
    mismatches = 0;
    gen_count = 0;
    n_beats = 0;
    n_settings = 1;
    n_sent = 0;
    n_received = 0;
    n_retries = 0;
    stim_state = t0_idle_state();
    pred_state = t0_idle_state();
    timing = '{bit_period: RstBitPeriod, sample_first: RstSampleFirst,
               sample_second: RstSampleSec, sample_third: RstSampleThird,
               error_check_time: RstErrorCheck, stop_guard_time: RstStopGuard,
               error_signal_end: RstErrSigEnd};
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // short timings, directed characters
    apply_timing('{8'd2, 8'd0, 8'd1, 8'd2, 8'd3, 8'd4, 8'd5}, 1'b1);
    gen_transfer(ACT_TX, 8'h00, 1'b0, 0);
    gen_transfer(ACT_TX, 8'hFF, 1'b1, 2);
    // line held low long enough to saturate the counter
    gen_transfer(ACT_TX, 8'h80, 1'b1, 256);
    gen_transfer(ACT_RX, 8'hA5, 1'b1, 0);
    gen_transfer(ACT_SPARE, 8'h3C, 1'b0, 0);
    gen_transfer(ACT_TICK, 8'hC3, 1'b0, 0);
    wait_settled();

    // zero period and sample times: every wait met at once
    apply_timing('{8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0}, 1'b0);
    gen_transfer(ACT_TX, 8'h3C, 1'b0, 0);
    gen_transfer(ACT_RX, 8'h69, 1'b1, 0);
    wait_settled();

    repeat (2) begin
      c.bit_period = 8'($urandom_range(1, 4));
      c.sample_first = 8'($urandom_range(0, 4));
      c.sample_second = 8'($urandom_range(0, 6));
      c.sample_third = 8'($urandom_range(0, 8));
      c.error_check_time = 8'($urandom_range(0, 12));
      c.stop_guard_time = 8'($urandom_range(0, 12));
      c.error_signal_end = 8'($urandom_range(0, 12));
      apply_timing(c, 1'b0);
      base = gen_count;
      while (gen_count - base < 30) begin
        pick = $urandom_range(99);
        if (pick < 45) kind = ACT_TX;
        else if (pick < 90) kind = ACT_RX;
        else if (pick < 95) kind = ACT_SPARE;
        else kind = ACT_TICK;
        gen_transfer(kind, 8'($urandom), $urandom_range(99) < 25, $urandom_range(0, 4));
      end
      wait_settled();
    end

    if (line_outputs_due.size() != 0) begin
      $display("%0t: %0d expected result beats never arrived", $time, line_outputs_due.size());
      mismatches++;
    end
    $display("checked %0d result beats under %0d timing settings", n_beats, n_settings);
    $display("%0d characters sent, %0d received, %0d parity retries", n_sent, n_received,
             n_retries);
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
